### hw/rtl/arfs_pkg.sv
// Shared constants, types and helper functions of the rotorcraft flight step block.
`timescale 1ns / 1ps
package arfs_pkg;

  // Fixed-point format of every angle, velocity and position.
  localparam int FRAC_BITS = 16;
  localparam int ATAN_ENTRIES = 24;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TICK = 2'd0;
  localparam logic [1:0] CFG_ATT  = 2'd1;
  localparam logic [1:0] CFG_VEL  = 2'd2;

  localparam logic [15:0] TICK_RESET = 16'd1092;
  localparam logic [16:0] ATT_RESET  = 17'd6896;
  localparam logic [16:0] VEL_RESET  = 17'd2675;
  localparam logic [16:0] SMOOTH_ONE = 17'd65536;

  // Scaling constants rounded to FRAC_BITS fraction bits.
  localparam logic signed [17:0] YAW_RATE_Q  = 18'sd78643;
  localparam logic signed [17:0] PITCH_MAX_Q = 18'sd22938;
  localparam logic signed [17:0] ROLL_MAX_Q  = 18'sd29491;
  localparam logic signed [21:0] SPEED_MAX_Q = 22'sd1638400;
  localparam logic signed [56:0] PI_Q        = 57'sd205887;
  localparam logic signed [56:0] TWO_PI_Q    = 57'sd411775;
  localparam logic signed [16:0] HOVER_Q     = 17'sd32768;

  // CORDIC constants in Q30.
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] HALF_PI_Q30     = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q30          = 34'sd3373259426;

  typedef logic signed [33:0] cword_t;

  // Status of the CORDIC unit.
  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  // Arctangent of 2^-i in Q30.
  function automatic cword_t atan_q30(input logic [4:0] i);
    cword_t r;
    case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Saturate a wide value to the velocity limit.
  function automatic logic signed [21:0] clamp_speed(input logic signed [56:0] v);
    logic signed [21:0] r;
    if (v > 57'(SPEED_MAX_Q)) begin
      r = SPEED_MAX_Q;
    end else if (v < -57'(SPEED_MAX_Q)) begin
      r = -SPEED_MAX_Q;
    end else begin
      r = v[21:0];
    end
    return r;
  endfunction

  // Saturate a wide value to the signed 32-bit range.
  function automatic logic signed [31:0] clamp_i32(input logic signed [56:0] v);
    logic signed [31:0] r;
    if (v > 57'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -57'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/arcade_rotor_flight_step_core.sv
// Top level of the rotorcraft flight step: sequencer around one shared multiplier.
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   pilot controls of one tick
//  m_axis    out        m_axis_tvalid/m_axis_tready   attitude, velocity, position
//  cfg       in         cfg_we                        tick length, smoothing factors
//
// A result is presented after its tick has passed the yaw and attitude steps, the rotation
// loop, the rotated targets, velocity and position, the ground check and the output
// register. The next tick is accepted only once the sequencer is back in idle, so a tick
// is not taken before the last one has been worked through. A new tick is accepted while
// a result waits; the sequencer holds its last step until that register is free. Reset
// is synchronous.
`timescale 1ns / 1ps
module arcade_rotor_flight_step_core
  import arfs_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst,
  // pedal_cmd[15:0], cyclic_fore[31:16], cyclic_side[47:32], collective_cmd[63:48]
  input  logic [63:0]   s_axis_tdata,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // heading[18:0], pitch_angle[34:19], roll_angle[50:35], speed_x[72:51],
  // speed_y[94:73], speed_z[116:95], place_x[148:117], place_y[179:149],
  // place_z[211:180], zero fill[215:212]
  output logic [215:0]  m_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [16:0]   cfg_data
);

  typedef enum logic [18:0] {
    ST_IDLE     = 19'h00001,
    ST_YAW_MUL  = 19'h00002,
    ST_YAW_ADD  = 19'h00004,
    ST_YAW_WRAP = 19'h00008,
    ST_PIT_TGT  = 19'h00010,
    ST_PIT_SMO  = 19'h00020,
    ST_ROL_TGT  = 19'h00040,
    ST_ROL_SMO  = 19'h00080,
    ST_CORDIC   = 19'h00100,
    ST_X_A      = 19'h00200,
    ST_X_B      = 19'h00400,
    ST_X_C      = 19'h00800,
    ST_Z_A      = 19'h01000,
    ST_Z_B      = 19'h02000,
    ST_Z_C      = 19'h04000,
    ST_VEL      = 19'h08000,
    ST_POS      = 19'h10000,
    ST_GROUND   = 19'h20000,
    ST_DONE     = 19'h40000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [15:0] tick_seconds;
  logic [16:0] attitude_smoothing;
  logic [16:0] velocity_smoothing;

  // Latched controls of the tick in progress.
  logic signed [15:0] pedal;
  logic signed [15:0] fore;
  logic signed [15:0] side;
  logic [15:0]        coll;

  // Flight state.
  logic signed [18:0] yaw;
  logic signed [15:0] pitch;
  logic signed [15:0] roll;
  logic signed [21:0] vel [3];
  logic signed [31:0] pos [3];
  logic signed [21:0] tgt_x;
  logic signed [21:0] tgt_z;
  logic [1:0]         axis;
  logic signed [56:0] acc;

  // Shared multiplier and rounding paths.
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod;
  logic signed [56:0] prod_w;
  logic signed [56:0] rnd15;
  logic signed [56:0] rnd16;
  logic signed [56:0] rnd31;
  logic signed [56:0] acc25;
  logic signed [56:0] rnd29;
  logic signed [56:0] vsum;
  logic signed [56:0] psum;

  logic signed [17:0] dt_b;
  logic signed [17:0] att_b;
  logic signed [17:0] velf_b;
  logic signed [16:0] coll_d;
  logic signed [21:0] tgt_y;
  logic signed [21:0] tgt_sel;
  logic signed [21:0] vel_sel;
  logic signed [31:0] pos_sel;
  logic signed [22:0] vel_diff;

  cordic_stat_t cstat;
  cword_t       sn;
  cword_t       cs;

  arfs_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (state == ST_ROL_SMO),
    .angle   (yaw),
    .stat    (cstat),
    .sin_q30 (sn),
    .cos_q30 (cs)
  );

  // Factors above one saturate to a jump to the target.
  assign dt_b   = {2'b00, tick_seconds};
  assign att_b  = {1'b0, (attitude_smoothing > SMOOTH_ONE) ? SMOOTH_ONE : attitude_smoothing};
  assign velf_b = {1'b0, (velocity_smoothing > SMOOTH_ONE) ? SMOOTH_ONE : velocity_smoothing};

  // Vertical target: twelve metres per second per unit of collective off hover.
  assign coll_d = $signed({1'b0, coll}) - HOVER_Q;
  assign tgt_y  = (22'(coll_d) <<< 3) + (22'(coll_d) <<< 2);

  assign vel_sel  = vel[axis];
  assign pos_sel  = pos[axis];
  assign tgt_sel  = (axis == 2'd0) ? tgt_x : ((axis == 2'd1) ? tgt_y : tgt_z);
  assign vel_diff = 23'(tgt_sel) - 23'(vel_sel);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_YAW_MUL: begin
        mul_a = 34'(pedal);
        mul_b = YAW_RATE_Q;
      end
      ST_YAW_ADD: begin
        mul_a = acc[33:0];
        mul_b = dt_b;
      end
      ST_PIT_TGT: begin
        mul_a = -34'(fore);
        mul_b = PITCH_MAX_Q;
      end
      ST_PIT_SMO: begin
        mul_a = acc[33:0] - 34'(pitch);
        mul_b = att_b;
      end
      ST_ROL_TGT: begin
        mul_a = 34'(side);
        mul_b = ROLL_MAX_Q;
      end
      ST_ROL_SMO: begin
        mul_a = acc[33:0] - 34'(roll);
        mul_b = att_b;
      end
      ST_X_A: begin
        mul_a = cs;
        mul_b = 18'(fore);
      end
      ST_X_B: begin
        mul_a = sn;
        mul_b = 18'(side);
      end
      ST_Z_A: begin
        mul_a = cs;
        mul_b = 18'(side);
      end
      ST_Z_B: begin
        mul_a = sn;
        mul_b = 18'(fore);
      end
      ST_VEL: begin
        mul_a = 34'(vel_diff);
        mul_b = velf_b;
      end
      ST_POS: begin
        mul_a = 34'(vel_sel);
        mul_b = dt_b;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Rounding shifts: round to nearest, ties upward.
  assign prod   = mul_a * mul_b;
  assign prod_w = 57'(prod);
  assign rnd15  = (prod_w + 57'sd16384) >>> 15;
  assign rnd16  = (prod_w + (57'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign rnd31  = (prod_w + 57'sd1073741824) >>> 31;
  assign acc25  = (acc <<< 4) + (acc <<< 3) + acc;
  assign rnd29  = (acc25 + 57'sd268435456) >>> 29;
  assign vsum   = 57'(vel_sel) + rnd16;
  assign psum   = 57'(pos_sel) + rnd16;

  assign s_axis_tready = (state == ST_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_seconds       <= TICK_RESET;
      attitude_smoothing <= ATT_RESET;
      velocity_smoothing <= VEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TICK: tick_seconds       <= cfg_data[15:0];
        CFG_ATT:  attitude_smoothing <= cfg_data;
        CFG_VEL:  velocity_smoothing <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and flight state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      yaw           <= '0;
      pitch         <= '0;
      roll          <= '0;
      axis          <= '0;
      for (int k = 0; k < 3; k++) begin
        vel[k] <= '0;
        pos[k] <= '0;
      end
    end else begin
      // The output register is loaded again in the last step of the sequence.
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            pedal <= s_axis_tdata[15:0];
            fore  <= s_axis_tdata[31:16];
            side  <= s_axis_tdata[47:32];
            coll  <= s_axis_tdata[63:48];
            state <= ST_YAW_MUL;
          end
        end
        ST_YAW_MUL: begin
          acc   <= prod_w;
          state <= ST_YAW_ADD;
        end
        ST_YAW_ADD: begin
          acc   <= 57'(yaw) + rnd31;
          state <= ST_YAW_WRAP;
        end
        ST_YAW_WRAP: begin
          // Keep the heading inside plus or minus pi.
          if (acc > PI_Q) begin
            yaw <= 19'(acc - TWO_PI_Q);
          end else if (acc < -PI_Q) begin
            yaw <= 19'(acc + TWO_PI_Q);
          end else begin
            yaw <= acc[18:0];
          end
          state <= ST_PIT_TGT;
        end
        ST_PIT_TGT: begin
          acc   <= rnd15;
          state <= ST_PIT_SMO;
        end
        ST_PIT_SMO: begin
          pitch <= pitch + rnd16[15:0];
          state <= ST_ROL_TGT;
        end
        ST_ROL_TGT: begin
          acc   <= rnd15;
          state <= ST_ROL_SMO;
        end
        ST_ROL_SMO: begin
          roll  <= roll + rnd16[15:0];
          state <= ST_CORDIC;
        end
        ST_CORDIC: begin
          if (cstat.done) begin
            state <= ST_X_A;
          end
        end
        // Body-frame target rotated into the world frame.
        ST_X_A: begin
          acc   <= prod_w;
          state <= ST_X_B;
        end
        ST_X_B: begin
          acc   <= acc + prod_w;
          state <= ST_X_C;
        end
        ST_X_C: begin
          tgt_x <= clamp_speed(rnd29);
          state <= ST_Z_A;
        end
        ST_Z_A: begin
          acc   <= prod_w;
          state <= ST_Z_B;
        end
        ST_Z_B: begin
          acc   <= acc - prod_w;
          state <= ST_Z_C;
        end
        ST_Z_C: begin
          tgt_z <= clamp_speed(rnd29);
          axis  <= 2'd0;
          state <= ST_VEL;
        end
        // Per axis: smooth the velocity, then integrate the position.
        ST_VEL: begin
          vel[axis] <= clamp_speed(vsum);
          state     <= ST_POS;
        end
        ST_POS: begin
          pos[axis] <= clamp_i32(psum);
          if (axis == 2'd2) begin
            state <= ST_GROUND;
          end else begin
            axis  <= axis + 2'd1;
            state <= ST_VEL;
          end
        end
        ST_GROUND: begin
          // Below ground the height is held at zero and descent stopped.
          if (pos[1] < 0) begin
            pos[1] <= '0;
            if (vel[1] < 0) begin
              vel[1] <= '0;
            end
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {4'b0, pos[2], pos[1][30:0], pos[0], vel[2], vel[1], vel[0],
                              roll, pitch, yaw};
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/arfs_cordic.sv
// Iterative CORDIC unit producing sine and cosine of the heading, one rotation per cycle.
`timescale 1ns / 1ps
module arfs_cordic
  import arfs_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [18:0]  angle,
  output cordic_stat_t        stat,
  output cword_t              sin_q30,
  output cword_t              cos_q30
);

  localparam int CW = $clog2(STEPS + 1);

  cword_t x;
  cword_t y;
  cword_t z;
  cword_t z_init;
  cword_t atan_i;
  logic [CW-1:0] step;
  logic flip;

  // The heading is moved to Q30 and folded into plus or minus half pi.
  assign z_init = {angle[18], angle, 14'b0};
  assign atan_i = atan_q30(5'(step));

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      step <= '0;
    end else begin
      if (start) begin
        x         <= CORDIC_GAIN_Q30;
        y         <= '0;
        step      <= '0;
        stat.busy <= 1'b1;
        stat.done <= 1'b0;
        if (z_init > HALF_PI_Q30) begin
          z    <= z_init - PI_Q30;
          flip <= 1'b1;
        end else if (z_init < -HALF_PI_Q30) begin
          z    <= z_init + PI_Q30;
          flip <= 1'b1;
        end else begin
          z    <= z_init;
          flip <= 1'b0;
        end
      end else if (stat.busy) begin
        if (step == CW'(STEPS)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
          sin_q30   <= flip ? -y : y;
          cos_q30   <= flip ? -x : x;
        end else begin
          // One micro-rotation towards zero residual angle.
          stat.done <= 1'b0;
          if (z >= 0) begin
            x <= x - (y >>> step);
            y <= y + (x >>> step);
            z <= z - atan_i;
          end else begin
            x <= x + (y >>> step);
            y <= y - (x >>> step);
            z <= z + atan_i;
          end
          step <= step + 1'b1;
        end
      end else begin
        stat.done <= 1'b0;
      end
    end
  end

endmodule

### bench/arcade_rotor_flight_step_core_check.sv
// Flight step checker: follows the tick channel, predicts each result and compares it.
`timescale 1ns / 1ps
module arcade_rotor_flight_step_core_check
  import arfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [63:0]  s_axis_tdata,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [215:0] m_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [31:0] place_z;
    logic [30:0] place_y;
    logic [31:0] place_x;
    logic [21:0] speed_z;
    logic [21:0] speed_y;
    logic [21:0] speed_x;
    logic [15:0] roll_angle;
    logic [15:0] pitch_angle;
    logic [18:0] heading;
  } flight_out_t;

  localparam int TURNS = 16;
  localparam longint SPD = 1638400;

  // Shadow of the flight state and the registers.
  longint dt_q, att_a, vel_a;
  longint yaw, pitch, roll;
  longint vel[3];
  longint pos[3];
  flight_out_t expected_ticks[$];

  // Arithmetic shift right rounding to nearest, ties upward; SystemVerilog >>> on signed longint floors.
  function automatic longint rshift(longint x, int s);
    if (s == 0) return x;
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint limit(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint ease(longint cur, longint tgt, longint a);
    longint f;
    f = a > 65536 ? 65536 : a;
    return cur + rshift(f * (tgt - cur), 16);
  endfunction

  // CORDIC rotation giving sine and cosine in Q30.
  task automatic rotate_heading(input longint ang, output longint sn, output longint cs);
    longint z, x, y, dx, dy;
    bit flip;
    z = ang * (longint'(1) << 14);
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > longint'(HALF_PI_Q30)) begin
      z -= longint'(PI_Q30);
      flip = 1;
    end else if (z < -longint'(HALF_PI_Q30)) begin
      z += longint'(PI_Q30);
      flip = 1;
    end
    for (int i = 0; i < TURNS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  // Advance the flight state by one tick and queue the expected result.
  task automatic predict_tick(input logic [63:0] d);
    longint pedal, fore, side, coll, sn, cs;
    longint tgt[3];
    flight_out_t r;
    pedal = longint'($signed(d[15:0]));
    fore  = longint'($signed(d[31:16]));
    side  = longint'($signed(d[47:32]));
    coll  = longint'(d[63:48]);
    yaw += rshift(pedal * 78643 * dt_q, 31);
    if (yaw > 205887) yaw -= 411775;
    else if (yaw < -205887) yaw += 411775;
    pitch = ease(pitch, rshift(-fore * 22938, 15), att_a);
    roll  = ease(roll, rshift(side * 29491, 15), att_a);
    rotate_heading(yaw, sn, cs);
    tgt[0] = limit(rshift((fore * cs + side * sn) * 25, 29), -SPD, SPD);
    tgt[2] = limit(rshift((side * cs - fore * sn) * 25, 29), -SPD, SPD);
    tgt[1] = rshift((coll - 32768) * 12 * 65536, 16);
    for (int k = 0; k < 3; k++) begin
      vel[k] = limit(ease(vel[k], tgt[k], vel_a), -SPD, SPD);
      pos[k] = limit(pos[k] + rshift(vel[k] * dt_q, 16), -64'sd2147483648, 64'sd2147483647);
    end
    if (pos[1] < 0) begin
      pos[1] = 0;
      if (vel[1] < 0) vel[1] = 0;
    end
    r.heading = yaw[18:0];
    r.pitch_angle = pitch[15:0];
    r.roll_angle = roll[15:0];
    r.speed_x = vel[0][21:0];
    r.speed_y = vel[1][21:0];
    r.speed_z = vel[2][21:0];
    r.place_x = pos[0][31:0];
    r.place_y = pos[1][30:0];
    r.place_z = pos[2][31:0];
    expected_ticks.push_back(r);
  endtask

  task automatic match_field(input string name, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Watch both channels and the register port at every edge.
  always @(posedge clk) begin
    flight_out_t got, want;
    if (rst) begin
      dt_q = 1092; att_a = 6896; vel_a = 2675;
      yaw = 0; pitch = 0; roll = 0;
      for (int k = 0; k < 3; k++) begin
        vel[k] = 0; pos[k] = 0;
      end
      expected_ticks.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TICK: dt_q = longint'(cfg_data[15:0]);
          CFG_ATT:  att_a = longint'(cfg_data);
          CFG_VEL:  vel_a = longint'(cfg_data);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_tick(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[211:0];
        if (expected_ticks.size() == 0) begin
          $error("result transaction with no tick outstanding");
          fail_count++;
        end else begin
          want = expected_ticks.pop_front();
          match_field("heading", want.heading, got.heading);
          match_field("pitch_angle", want.pitch_angle, got.pitch_angle);
          match_field("roll_angle", want.roll_angle, got.roll_angle);
          match_field("speed_x", want.speed_x, got.speed_x);
          match_field("speed_y", want.speed_y, got.speed_y);
          match_field("speed_z", want.speed_z, got.speed_z);
          match_field("place_x", want.place_x, got.place_x);
          match_field("place_y", want.place_y, got.place_y);
          match_field("place_z", want.place_z, got.place_z);
          match_field("zero fill", 0, m_axis_tdata[215:212]);
        end
      end
    end
    pending = expected_ticks.size();
  end

endmodule

### bench/arcade_rotor_flight_step_core_test.sv
// Flight step testbench top: clock, reset, register settings, tick stimulus and verdict.
`timescale 1ns / 1ps
module arcade_rotor_flight_step_core_test
  import arfs_pkg::*;
();

  // Register index outside the register list, written to check it is ignored.
  localparam logic [1:0] CFG_NONE = 2'd3;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic [63:0]  s_axis_tdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [215:0] m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = CFG_TICK;
  logic [16:0]  cfg_data = '0;
  int           fail_count;
  int           pending;
  bit           calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  arcade_rotor_flight_step_core DUT (
    .clk(clk), .rst(rst),
    .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  arcade_rotor_flight_step_core_check checker_i (
    .clk(clk), .rst(rst),
    .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // The receiver stalls at random except during the calm stretch.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm || ($urandom_range(99) >= 12);
  end

  // Offer one tick transaction, with an occasional idle gap first.
  // The valid stays high after acceptance until the next gap or the next transaction.
  task automatic send_tick(input logic [15:0] pedal, input logic [15:0] fore,
                           input logic [15:0] side, input logic [15:0] coll);
    while (!calm && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata <= {coll, side, fore, pedal};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Wait for all results, then for the sequencer to go idle, then write one register.
  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] edgy16();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly realistic steering with some full-scale values.
  task automatic random_ticks(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(3) == 0)
        send_tick(edgy16(), edgy16(), edgy16(), edgy16());
      else
        send_tick(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(65535)));
    end
  endtask

  initial begin
    logic [15:0] ticks [5];
    logic [16:0] smooths [5];
    ticks = '{16'd1092, 16'd65535, 16'd1, 16'd0, 16'd30000};
    smooths = '{17'd6896, 17'd65536, 17'd0, 17'd131071, 17'd40000};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, climb and ground contact, hard yaw to force the wrap.
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h8000);
    send_tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_tick(16'h8000, 16'h8000, 16'h8000, 16'h0000);
    send_tick(16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000);
    send_tick(16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF);
    write_reg(CFG_TICK, 17'd65535);
    write_reg(CFG_ATT, 17'd131071);
    write_reg(CFG_VEL, 17'd65536);
    for (int n = 0; n < 6; n++) send_tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    for (int n = 0; n < 6; n++) send_tick(16'h8000, 16'h8000, 16'h8000, 16'h0000);
    write_reg(CFG_TICK, 17'd0);
    write_reg(CFG_NONE, 17'h1FFFF);
    send_tick(16'h7FFF, 16'h1234, 16'hEDCB, 16'h9000);
    send_tick(16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000);

    // Random phases across register settings; the third phase runs without idling.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_TICK, {1'b0, ticks[ph]});
      write_reg(CFG_ATT, smooths[ph]);
      write_reg(CFG_VEL, smooths[(ph + 2) % 5]);
      calm = (ph == 2);
      random_ticks(165);
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("arcade_rotor_flight_step_core_test: done, clean");
    end else begin
      $display("arcade_rotor_flight_step_core_test: done, errors");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #2000000;
    $display("arcade_rotor_flight_step_core_test: done, errors");
    $finish;
  end

endmodule

### files.f
hw/rtl/arfs_pkg.sv
hw/rtl/arfs_cordic.sv
hw/rtl/arcade_rotor_flight_step_core.sv
bench/arcade_rotor_flight_step_core_check.sv
bench/arcade_rotor_flight_step_core_test.sv
